// ===== hdl/lbs_pkg.sv =====
`default_nettype none
package lbs_pkg;

  typedef enum logic [1:0] {
    CMD_ANIM = 2'd0,
    CMD_INV  = 2'd1,
    CMD_INFL = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    K_ANIM = 2'd0,
    K_INV  = 2'd1,
    K_INFL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_BMAT = 2'd0,
    OP_AMAT = 2'd1,
    OP_WGT  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_BMAT  = 3'd1,
    ST_DRN_B = 3'd2,
    ST_AMAT  = 3'd3,
    ST_DRN_A = 3'd4,
    ST_WGT   = 3'd5,
    ST_DRN_W = 3'd6,
    ST_EMIT  = 3'd7
  } state_e;

  localparam logic [16:0] WeightOne = 17'd65536;
  localparam logic signed [31:0] OneQ16 = 32'sd65536;

  // one queued item, already classified
  typedef struct packed {
    kind_e            kind;
    logic [4:0]       bone;
    logic [3:0]       elem;
    logic [31:0]      value;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] nrm;
    logic [16:0]      weight;
    logic             active;
    logic             last;
  } q_item_t;

  function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd32768;
    return s[63:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sd2147483647) return 32'sh7fffffff;
    else if (x < -50'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
    if (x > 49'sh07fffffffffff) return 48'sh7fffffffffff;
    else if (x < -49'sh0800000000000) return 48'sh800000000000;
    else return x[47:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lbs_ram.sv =====
`default_nettype none
module lbs_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/lbs_front.sv =====
`default_nettype none
module lbs_front #(
  parameter int MAX_BONES = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [4:0]       bone_i,
  input  wire logic [3:0]       elem_i,
  input  wire logic [31:0]      value_i,
  input  wire logic [2:0][31:0] pos_i,
  input  wire logic [2:0][31:0] nrm_i,
  input  wire logic [16:0]      weight_i,
  input  wire logic             last_i,
  output lbs_pkg::q_item_t      item_o,
  output logic                  item_vld_o,
  input  wire logic             pop_i
);
  import lbs_pkg::*;

  q_item_t    fifo_q [2];
  q_item_t    cls;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       bone_ok, push, pop;

  always_comb begin
    bone_ok = 32'(bone_i) < MAX_BONES;
    cls.bone   = bone_i;
    cls.elem   = elem_i;
    cls.value  = value_i;
    cls.pos    = pos_i;
    cls.nrm    = nrm_i;
    cls.weight = (weight_i > WeightOne) ? WeightOne : weight_i;
    cls.last   = last_i;
    cls.active = bone_ok && (weight_i != 17'd0);
    cls.kind   = K_INFL;
    push       = 1'b0;
    case (cmd_i)
      CMD_ANIM: begin
        cls.kind = K_ANIM;
        push     = bone_ok;
      end
      CMD_INV: begin
        cls.kind = K_INV;
        push     = bone_ok;
      end
      CMD_INFL: begin
        cls.kind = K_INFL;
        push     = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign item_vld_o = (cnt_q != 2'd0);
  assign item_o     = fifo_q[rd_ptr_q];
  assign pop        = pop_i && item_vld_o;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o && push) fifo_q[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (in_valid_i && !in_stall_o && push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'((in_valid_i && !in_stall_o && push) ? 1 : 0) - 2'(pop ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lbs_back.sv =====
`default_nettype none
module lbs_back #(
  parameter int MAX_BONES = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lbs_pkg::q_item_t item_i,
  input  wire logic             item_vld_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [2:0][31:0]      skin_pos_o,
  output logic [2:0][31:0]      skin_nrm_o
);
  import lbs_pkg::*;

  localparam int AW = $clog2(MAX_BONES * 16);

  state_e state_q, state_d;
  q_item_t itm_q;
  logic vec_sel_q;
  logic [3:0] cnt_q;

  logic run, issue, we_anim, we_inv, out_free, pipe_empty;
  op_e  op;
  logic [AW-1:0] raddr, waddr;
  logic [31:0] anim_rd, inv_rd;

  logic s1_vld_q, s2_vld_q;
  op_e  s1_op_q, s2_op_q;
  logic [3:0] s1_idx_q, s2_idx_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] opa, opb;

  logic signed [31:0] t_q [4];
  logic signed [31:0] u_q [3];
  logic signed [47:0] psum_q [3];
  logic signed [47:0] nsum_q [3];
  logic signed [49:0] row_q, row_new;
  logic signed [47:0] rnd;
  logic signed [47:0] acc_sel;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign pipe_empty = !s1_vld_q && !s2_vld_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:
        if (item_vld_i && item_i.kind == K_INFL) begin
          if (item_i.active) state_d = ST_BMAT;
          else if (item_i.last) state_d = ST_EMIT;
        end
      ST_BMAT:  if (cnt_q == 4'd15) state_d = ST_DRN_B;
      ST_DRN_B: if (pipe_empty) state_d = ST_AMAT;
      ST_AMAT:  if (cnt_q == 4'd11) state_d = ST_DRN_A;
      ST_DRN_A: if (pipe_empty) state_d = ST_WGT;
      ST_WGT:   if (cnt_q == 4'd2) state_d = ST_DRN_W;
      ST_DRN_W:
        if (pipe_empty) begin
          if (!vec_sel_q) state_d = ST_BMAT;
          else if (itm_q.last) state_d = ST_EMIT;
          else state_d = ST_IDLE;
        end
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    run   = 1'b0;
    issue = 1'b0;
    op    = OP_BMAT;
    pop_o = 1'b0;
    case (state_q)
      ST_IDLE: pop_o = item_vld_i;
      ST_BMAT: begin
        run = 1'b1; issue = 1'b1; op = OP_BMAT;
      end
      ST_AMAT: begin
        run = 1'b1; issue = 1'b1; op = OP_AMAT;
      end
      ST_WGT: begin
        run = 1'b1; issue = 1'b1; op = OP_WGT;
      end
      default: pop_o = 1'b0;
    endcase
  end

  assign we_anim = pop_o && item_i.kind == K_ANIM;
  assign we_inv  = pop_o && item_i.kind == K_INV;
  assign waddr   = AW'({item_i.bone, item_i.elem});
  assign raddr   = AW'({itm_q.bone, cnt_q});

  lbs_ram #(.Width(32), .Depth(MAX_BONES * 16)) u_anim_ram (
    .clk_i(clk_i), .we_i(we_anim), .waddr_i(waddr), .wdata_i(item_i.value),
    .raddr_i(raddr), .rdata_o(anim_rd)
  );

  lbs_ram #(.Width(32), .Depth(MAX_BONES * 16)) u_inv_ram (
    .clk_i(clk_i), .we_i(we_inv), .waddr_i(waddr), .wdata_i(item_i.value),
    .raddr_i(raddr), .rdata_o(inv_rd)
  );

  // multiplier operands
  always_comb begin
    opa = $signed(inv_rd);
    opb = t_q[s1_idx_q[1:0]];
    case (s1_op_q)
      OP_BMAT: begin
        opa = $signed(inv_rd);
        if (s1_idx_q[1:0] == 2'd3) opb = vec_sel_q ? 32'sd0 : OneQ16;
        else if (vec_sel_q) opb = $signed(itm_q.nrm[s1_idx_q[1:0]]);
        else opb = $signed(itm_q.pos[s1_idx_q[1:0]]);
      end
      OP_AMAT: begin
        opa = $signed(anim_rd);
        opb = t_q[s1_idx_q[1:0]];
      end
      OP_WGT: begin
        opa = u_q[s1_idx_q[1:0]];
        opb = $signed({15'd0, itm_q.weight});
      end
      default: opa = $signed(inv_rd);
    endcase
  end

  always_comb begin
    rnd     = rnd16(prod_q);
    row_new = row_q + 50'(rnd);
    acc_sel = vec_sel_q ? nsum_q[s2_idx_q[1:0]] : psum_q[s2_idx_q[1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.kind == K_INFL) itm_q <= item_i;
    prod_q <= opa * opb;
    if (s2_vld_q && s2_op_q != OP_WGT) begin
      if (s2_idx_q[1:0] == 2'd0) row_q <= 50'(rnd);
      else row_q <= row_new;
      if (s2_idx_q[1:0] == 2'd3) begin
        if (s2_op_q == OP_BMAT) t_q[s2_idx_q[3:2]] <= sat32(row_new);
        else u_q[s2_idx_q[3:2]] <= sat32(row_new);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vec_sel_q <= 1'b0;
      cnt_q     <= 4'd0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s1_op_q   <= OP_BMAT;
      s2_op_q   <= OP_BMAT;
      s1_idx_q  <= 4'd0;
      s2_idx_q  <= 4'd0;
      out_valid_o <= 1'b0;
      skin_pos_o  <= '0;
      skin_nrm_o  <= '0;
      for (int i = 0; i < 3; i++) begin
        psum_q[i] <= 48'sd0;
        nsum_q[i] <= 48'sd0;
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= run ? cnt_q + 4'd1 : 4'd0;
      s1_vld_q <= issue;
      s1_op_q  <= op;
      s1_idx_q <= cnt_q;
      s2_vld_q <= s1_vld_q;
      s2_op_q  <= s1_op_q;
      s2_idx_q <= s1_idx_q;
      if (state_q == ST_IDLE) vec_sel_q <= 1'b0;
      else if (state_q == ST_DRN_W && pipe_empty) vec_sel_q <= 1'b1;
      // weighted row into its accumulator
      if (s2_vld_q && s2_op_q == OP_WGT) begin
        if (vec_sel_q) nsum_q[s2_idx_q[1:0]] <= sat48(49'(acc_sel) + 49'(rnd));
        else psum_q[s2_idx_q[1:0]] <= sat48(49'(acc_sel) + 49'(rnd));
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_o <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          skin_pos_o[i] <= sat32(50'(psum_q[i]));
          skin_nrm_o[i] <= sat32(50'(nsum_q[i]));
          psum_q[i] <= 48'sd0;
          nsum_q[i] <= 48'sd0;
        end
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/linear_blend_skinning.sv =====
// matrix writes: taken by the back end while it is idle, behind a two-entry queue
// influence with zero weight or bone out of range: popped and skipped; when it is last, the vertex is emitted
// full influence: two vectors of 16 + 12 + 3 products on one 32x32 multiplier,
//   each pass draining the multiplier pipeline before the next; the vertex is emitted after it when it is last
// result registered from the emit state after the last weighted sum; input fills the queue meanwhile
// reset clears control, queue and accumulators; matrix memories are undefined until written
`default_nettype none
module linear_blend_skinning #(
  parameter int MAX_BONES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [4:0]  bone_i,
  input  wire logic [3:0]  elem_i,
  input  wire logic [31:0] value_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [31:0] nrm_x_i,
  input  wire logic [31:0] nrm_y_i,
  input  wire logic [31:0] nrm_z_i,
  input  wire logic [16:0] weight_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      skin_x_o,
  output logic [31:0]      skin_y_o,
  output logic [31:0]      skin_z_o,
  output logic [31:0]      skin_nx_o,
  output logic [31:0]      skin_ny_o,
  output logic [31:0]      skin_nz_o
);
  import lbs_pkg::*;

  q_item_t          item;
  logic             item_vld, pop;
  logic [2:0][31:0] skin_pos, skin_nrm;

  lbs_front #(.MAX_BONES(MAX_BONES)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .cmd_i(cmd_i), .bone_i(bone_i), .elem_i(elem_i), .value_i(value_i),
    .pos_i({pos_z_i, pos_y_i, pos_x_i}), .nrm_i({nrm_z_i, nrm_y_i, nrm_x_i}),
    .weight_i(weight_i), .last_i(last_i),
    .item_o(item), .item_vld_o(item_vld), .pop_i(pop)
  );

  lbs_back #(.MAX_BONES(MAX_BONES)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .item_i(item), .item_vld_i(item_vld), .pop_o(pop),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .skin_pos_o(skin_pos), .skin_nrm_o(skin_nrm)
  );

  assign skin_x_o  = skin_pos[0];
  assign skin_y_o  = skin_pos[1];
  assign skin_z_o  = skin_pos[2];
  assign skin_nx_o = skin_nrm[0];
  assign skin_ny_o = skin_nrm[1];
  assign skin_nz_o = skin_nrm[2];
endmodule
`default_nettype wire

// ===== dv/tb_linear_blend_skinning.sv =====
`default_nettype none
module tb_linear_blend_skinning;
  import lbs_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int NumItems = 1350;
  localparam int StallLimit = 4000;
  localparam int QuietFrom = 6000;
  localparam int QuietTo = 16000;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [4:0]       bone;
    logic [3:0]       elem;
    logic [31:0]      value;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] nrm;
    logic [16:0]      weight;
    logic             last;
  } skin_item_t;

  // x, y, z, nx, ny, nz from index 0 upwards
  typedef logic [5:0][31:0] skin_vtx_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = '0;
  logic [4:0] bone_i = '0;
  logic [3:0] elem_i = '0;
  logic [31:0] value_i = '0;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [31:0] nrm_x_i = '0, nrm_y_i = '0, nrm_z_i = '0;
  logic [16:0] weight_i = '0;
  logic last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] skin_x_o, skin_y_o, skin_z_o, skin_nx_o, skin_ny_o, skin_nz_o;

  linear_blend_skinning dut (.*);

  skin_item_t pending_items[$];
  skin_vtx_t  expected_vertices[$];
  skin_item_t cur_item;
  int  errors = 0;
  int  cycle_cnt = 0;
  int  quiet_cycles = 0;

  // shadow of the matrix stores and accumulators
  int     anim_mat[512];
  int     inv_mat[512];
  longint pos_sum[3];
  longint nrm_sum[3];
  bit     anim_set[512];
  bit     inv_set[512];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint q16_round(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clamp48(longint x);
    if (x > 64'sd140737488355327) return 64'sd140737488355327;
    if (x < -64'sd140737488355328) return -64'sd140737488355328;
    return x;
  endfunction

  function automatic void blend_vector(int b, logic [2:0][31:0] vec, longint w_comp,
                                       longint wt, bit is_nrm);
    longint v[4];
    longint t[4];
    longint s;
    longint u;
    for (int i = 0; i < 3; i++) v[i] = longint'(signed'(vec[i]));
    v[3] = w_comp;
    for (int r = 0; r < 4; r++) begin
      s = 0;
      for (int c = 0; c < 4; c++) s += q16_round(longint'(inv_mat[b*16 + r*4 + c]) * v[c]);
      t[r] = clamp32(s);
    end
    for (int r = 0; r < 3; r++) begin
      s = 0;
      for (int c = 0; c < 4; c++) s += q16_round(longint'(anim_mat[b*16 + r*4 + c]) * t[c]);
      u = clamp32(s);
      if (is_nrm) nrm_sum[r] = clamp48(nrm_sum[r] + q16_round(u * wt));
      else pos_sum[r] = clamp48(pos_sum[r] + q16_round(u * wt));
    end
  endfunction

  function automatic void skin_predict(skin_item_t it);
    longint wt;
    skin_vtx_t v;
    case (it.cmd)
      CMD_ANIM: anim_mat[{it.bone, it.elem}] = it.value;
      CMD_INV:  inv_mat[{it.bone, it.elem}] = it.value;
      CMD_INFL: begin
        wt = (it.weight > WeightOne) ? 64'sd65536 : longint'(it.weight);
        if (wt != 0) begin
          blend_vector(int'(it.bone), it.pos, 64'sd65536, wt, 1'b0);
          blend_vector(int'(it.bone), it.nrm, 64'sd0, wt, 1'b1);
        end
        if (it.last) begin
          for (int i = 0; i < 3; i++) begin
            v[i] = 32'(clamp32(pos_sum[i]));
            v[3+i] = 32'(clamp32(nrm_sum[i]));
            pos_sum[i] = 0;
            nrm_sum[i] = 0;
          end
          expected_vertices.insert(expected_vertices.size(), v);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
    errors++;
  endtask

  // stimulus helpers
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      6, 7: return $urandom;
      8: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return '0;
    endcase
  endfunction

  function automatic logic [31:0] rand_elem_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      7: return $urandom;
      8: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return '0;
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WeightOne;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(1, 65536));
    endcase
  endfunction

  function automatic bit bone_ready(int b);
    for (int e = 0; e < 16; e++) begin
      if (!inv_set[b*16 + e]) return 1'b0;
      if (e < 12 && !anim_set[b*16 + e]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_write(logic [1:0] cmd, int b, int e, logic [31:0] val);
    skin_item_t it;
    it = '0;
    it.cmd = cmd;
    it.bone = 5'(b);
    it.elem = 4'(e);
    it.value = val;
    it.pos = {$urandom, $urandom, $urandom};
    it.nrm = {$urandom, $urandom, $urandom};
    it.weight = 17'($urandom);
    it.last = 1'($urandom_range(0, 1));
    if (cmd == CMD_ANIM) anim_set[b*16 + e] = 1'b1;
    if (cmd == CMD_INV) inv_set[b*16 + e] = 1'b1;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void push_influence(int b, logic [16:0] wt, bit lst, bit extreme);
    skin_item_t it;
    it = '0;
    it.cmd = CMD_INFL;
    it.bone = 5'(b);
    it.elem = 4'($urandom);
    it.value = $urandom;
    for (int i = 0; i < 3; i++) begin
      it.pos[i] = extreme ? (($urandom_range(0, 1)) ? 32'h7fff_ffff : 32'h8000_0000)
                          : rand_coord();
      it.nrm[i] = extreme ? (($urandom_range(0, 1)) ? 32'h7fff_ffff : 32'h8000_0000)
                          : rand_coord();
    end
    it.weight = wt;
    it.last = lst;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic int pick_ready_bone();
    int b;
    for (int k = 0; k < 6; k++) begin
      b = $urandom_range(0, 31);
      if (bone_ready(b)) return b;
    end
    return $urandom_range(0, 3);
  endfunction

  // stimulus and end of run
  initial begin
    int n_infl;
    int roll;
    skin_item_t junk;
    logic [287:0] noise;
    automatic int boot_bones[6] = '{0, 1, 2, 3, 16, 31};

    // bone 0 is the identity for both matrices, the others random
    foreach (boot_bones[k]) begin
      for (int e = 0; e < 16; e++) begin
        if (boot_bones[k] == 0) begin
          push_write(CMD_INV, 0, e, (e % 5 == 0) ? 32'h0001_0000 : 32'h0);
          push_write(CMD_ANIM, 0, e, (e % 5 == 0) ? 32'h0001_0000 : 32'h0);
        end else begin
          push_write(CMD_INV, boot_bones[k], e, rand_elem_value());
          push_write(CMD_ANIM, boot_bones[k], e, rand_elem_value());
        end
      end
    end

    // directed: weights at the edges, above one, zero, extremes, unused command
    push_influence(0, WeightOne, 1'b1, 1'b0);
    push_influence(0, WeightOne, 1'b1, 1'b1);
    push_influence(1, 17'h1ffff, 1'b1, 1'b1);
    push_influence(1, 17'd65537, 1'b0, 1'b0);
    push_influence(2, 17'd1, 1'b1, 1'b0);
    push_influence(5, 17'd0, 1'b1, 1'b0);
    push_influence(31, 17'd32768, 1'b0, 1'b1);
    push_influence(16, 17'd32768, 1'b0, 1'b1);
    push_influence(20, 17'd0, 1'b0, 1'b0);
    push_influence(3, 17'd0, 1'b1, 1'b0);
    junk = '1;
    junk.cmd = CmdUnused;
    pending_items.insert(pending_items.size(), junk);
    push_write(CMD_ANIM, 31, 15, 32'h8000_0000);
    push_write(CMD_INV, 31, 15, 32'h7fff_ffff);
    push_influence(31, WeightOne, 1'b1, 1'b1);

    // random: mostly whole vertices on loaded bones, some rewrites and noise
    while (pending_items.size() < NumItems) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        n_infl = $urandom_range(1, 4);
        for (int k = 0; k < n_infl; k++) begin
          push_influence(pick_ready_bone(), rand_weight(), k == n_infl - 1,
                         $urandom_range(0, 29) == 0);
        end
      end else if (roll < 88) begin
        push_write($urandom_range(0, 1) ? CMD_ANIM : CMD_INV, $urandom_range(0, 31),
                   $urandom_range(0, 15), rand_elem_value());
      end else if (roll < 93) begin
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom};
        junk = noise[$bits(skin_item_t)-1:0];
        junk.cmd = CmdUnused;
        pending_items.insert(pending_items.size(), junk);
      end else begin
        // zero weight on any bone, loaded or not
        push_influence($urandom_range(0, 31), 17'd0, 1'($urandom_range(0, 1)), 1'b0);
      end
    end
    // close any open vertex
    push_influence(0, WeightOne, 1'b1, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_i || expected_vertices.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // driver
  bit in_taken = 1'b0;
  always @(negedge clk_i) begin
    bit quiet;
    quiet = cycle_cnt >= QuietFrom && cycle_cnt < QuietTo;
    if (rst_ni) begin
      out_stall_i <= !quiet && $urandom_range(0, 99) < 20;
      if (!in_valid_i || in_taken) begin
        if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 20)) begin
          cur_item = pending_items.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= cur_item.cmd;
          bone_i <= cur_item.bone;
          elem_i <= cur_item.elem;
          value_i <= cur_item.value;
          pos_x_i <= cur_item.pos[0];
          pos_y_i <= cur_item.pos[1];
          pos_z_i <= cur_item.pos[2];
          nrm_x_i <= cur_item.nrm[0];
          nrm_y_i <= cur_item.nrm[1];
          nrm_z_i <= cur_item.nrm[2];
          weight_i <= cur_item.weight;
          last_i <= cur_item.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    skin_vtx_t got;
    skin_vtx_t want;
    automatic string names[6] = '{"skin_x", "skin_y", "skin_z", "skin_nx", "skin_ny",
                                  "skin_nz"};
    bit moved;
    moved = 1'b0;
    cycle_cnt <= cycle_cnt + 1;
    in_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      skin_predict(cur_item);
      moved = 1'b1;
    end
    if (out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      got = {skin_nz_o, skin_ny_o, skin_nx_o, skin_z_o, skin_y_o, skin_x_o};
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected vertex skin_x", got[0], '0);
      end else begin
        want = expected_vertices.pop_front();
        for (int i = 0; i < 6; i++)
          if (got[i] !== want[i]) report_mismatch(names[i], got[i], want[i]);
      end
    end
    if (moved || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
`default_nettype wire
